// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication.
`define ASSERT_HOLD(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/lpsm_pkg.sv =====
// Package for the lidar packet parser and scan map.
// Holds state types, codes, constants and the CORDIC angle table; no dependencies.
package lpsm_pkg;

    localparam int MAP_ENTRIES_DEF     = 360;
    localparam int MAX_FRAME_BYTES_DEF = 515;
    localparam int FULL_TURN           = 23040;
    localparam int CORDIC_STEPS        = 17;
    localparam int HEAD_BYTES          = 10;

    localparam logic [7:0]  SYNC_LO   = 8'hAA;
    localparam logic [7:0]  SYNC_HI   = 8'h55;
    localparam logic [15:0] SYNC_WORD = 16'h55AA;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] STAT_NONE = 2'd0;
    localparam logic [1:0] STAT_OK   = 2'd1;
    localparam logic [1:0] STAT_CSUM = 2'd2;
    localparam logic [1:0] STAT_BIG  = 2'd3;

    localparam logic [31:0] X_GAIN   = 32'd7765;
    localparam logic [31:0] Y_BASE   = 32'd677108;
    localparam logic [31:0] Y_GAIN   = 32'd1090;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_HEAD = 2'd1,
        PH_SAMP = 2'd2
    } parse_phase_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAPRD,
        ST_CHK,
        ST_STEP,
        ST_DIV,
        ST_RDLO,
        ST_RDHI,
        ST_LOAD,
        ST_CORD,
        ST_FIX,
        ST_WRITE,
        ST_NEXT,
        ST_FIN
    } ctl_state_t;

    function automatic logic signed [23:0] atan_val(input logic [4:0] k);
        logic signed [23:0] v;
        unique case (k)
            5'd0:    v = 24'sd737280;
            5'd1:    v = 24'sd435242;
            5'd2:    v = 24'sd229970;
            5'd3:    v = 24'sd116736;
            5'd4:    v = 24'sd58595;
            5'd5:    v = 24'sd29326;
            5'd6:    v = 24'sd14667;
            5'd7:    v = 24'sd7334;
            5'd8:    v = 24'sd3667;
            5'd9:    v = 24'sd1833;
            5'd10:   v = 24'sd917;
            5'd11:   v = 24'sd458;
            5'd12:   v = 24'sd229;
            5'd13:   v = 24'sd115;
            5'd14:   v = 24'sd57;
            5'd15:   v = 24'sd29;
            5'd16:   v = 24'sd14;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/lidar_packet_parser_scan_map_top.sv =====
// Lidar packet parser with a per-degree distance map.
// Depends on lpsm_pkg; holds the frame store and the range map memories.
//
// Usage: the slave channel carries one beat per item. s_tuser is the operation
// (0 = received sensor byte, 1 = read a map entry). Each beat gives exactly one
// master beat: distance in m_tdata, packet status in m_tuser.
// A byte that does not end a frame gives its result in the cycle after acceptance;
// a map read passes the map read register, ST_MAPRD and ST_FIN before its result goes out.
// A byte that ends a frame starts the frame walk: a checksum check (a mismatch
// ends the walk with a checksum status), the step set-up, a step division
// when there are two or more samples, then per sample two frame-store reads,
// 17 CORDIC iterations and the map write, or only the two reads for a zero
// sample. The CORDIC unit and the single frame-store read port are shared by
// all samples. s_tready stays low during the walk.
// After reset the map is cleared one entry per cycle, all MAP_ENTRIES entries,
// before the first beat is accepted.
// When the receiver stalls, the result beat is held and no new beat is taken
// until it has been passed on.
module lidar_packet_parser_scan_map_top #(
    parameter int MAP_ENTRIES     = lpsm_pkg::MAP_ENTRIES_DEF,
    parameter int MAX_FRAME_BYTES = lpsm_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rx_byte[7:0], angle_index[17:8], zero[23:18]
    input  logic        s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // range_mm[13:0], zero[15:14]
    output logic [1:0]  m_tuser    // packet_status[1:0]
);

    localparam int FA_W = $clog2(MAX_FRAME_BYTES);
    localparam int MA_W = $clog2(MAP_ENTRIES);

    lpsm_pkg::ctl_state_t   state_reg, state_next;
    lpsm_pkg::parse_phase_t phase_reg, phase_next;

    logic [7:0]  prev_reg, prev_next;
    logic [9:0]  pos_reg, pos_next;
    logic [9:0]  len_reg, len_next;
    logic [7:0]  lsn_reg, lsn_next;
    logic [15:0] fsa_reg, fsa_next;
    logic [15:0] lsa_reg, lsa_next;
    logic [15:0] cc_reg, cc_next;
    logic [15:0] cs_reg, cs_next;
    logic [14:0] a0_reg, a0_next;
    logic [14:0] a1_reg, a1_next;
    logic [14:0] dq_reg, dq_next;
    logic [7:0]  rem_reg, rem_next;
    logic [14:0] step_reg, step_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0]  samp_reg, samp_next;
    logic [9:0]  ptr_reg, ptr_next;
    logic [7:0]  lo_reg, lo_next;
    logic [15:0] r_reg, r_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [23:0] z_reg, z_next;
    logic [4:0]  k_reg, k_next;
    logic signed [17:0] a_reg, a_next;
    logic [MA_W-1:0] clr_reg, clr_next;
    logic        rdok_reg, rdok_next;
    logic [1:0]  fin_stat_reg, fin_stat_next;
    logic [13:0] fin_dist_reg, fin_dist_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [13:0] dist_reg, dist_next;
    logic [1:0]  stat_reg, stat_next;

    logic [7:0]  frame_mem [MAX_FRAME_BYTES];
    logic [7:0]  fm_rdata_reg;
    logic        fw_en;
    logic [FA_W-1:0] fw_addr;
    logic [FA_W-1:0] fr_addr;
    logic [13:0] map_mem [MAP_ENTRIES];
    logic [13:0] map_rdata_reg;
    logic        mw_en;
    logic [MA_W-1:0] mw_addr;
    logic [13:0] mw_data;
    logic [MA_W-1:0] mr_addr;

    logic        out_free;
    logic        accept;
    logic [7:0]  rx_b;
    logic [9:0]  a_idx;
    logic        in_frame;
    logic [9:0]  pos_inc;
    logic [9:0]  len_calc;
    logic        head_done;
    logic        too_big;
    logic        samp_now;
    logic        finish;
    logic signed [15:0] d_s;
    logic signed [15:0] d_adj;
    logic [8:0]  rem_sh;
    logic [8:0]  divisor;
    logic        q_bit;
    logic [15:0] r_word;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [23:0] zr;
    logic signed [17:0] aw;
    logic [17:0] aw_r;
    logic [11:0] idx12;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == lpsm_pkg::ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign rx_b      = s_tdata[7:0];
    assign a_idx     = s_tdata[17:8];
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, dist_reg};
    assign m_tuser   = stat_reg;

    assign in_frame  = (phase_reg == lpsm_pkg::PH_HEAD) || (phase_reg == lpsm_pkg::PH_SAMP);
    assign pos_inc   = pos_reg + 10'd1;
    assign len_calc  = 10'(lpsm_pkg::HEAD_BYTES) + {1'b0, lsn_reg, 1'b0};
    assign head_done = (phase_reg == lpsm_pkg::PH_HEAD) && (pos_inc >= 10'(lpsm_pkg::HEAD_BYTES));
    assign too_big   = head_done && (11'(len_calc) > 11'(MAX_FRAME_BYTES));
    assign samp_now  = (phase_reg == lpsm_pkg::PH_SAMP) || (head_done && !too_big);
    assign finish    = samp_now &&
                       (pos_inc >= ((phase_reg == lpsm_pkg::PH_HEAD) ? len_calc : len_reg));

    assign d_s     = $signed({1'b0, a1_reg}) - $signed({1'b0, a0_reg});
    assign d_adj   = (d_s < 16'sd0) ? d_s + 16'(lpsm_pkg::FULL_TURN) : d_s;
    assign rem_sh  = {rem_reg, dq_reg[14]};
    assign divisor = {1'b0, lsn_reg - 8'd1};
    assign q_bit   = rem_sh >= divisor;
    assign r_word  = {fm_rdata_reg, lo_reg};
    assign xs      = x_reg >>> k_reg;
    assign ys      = y_reg >>> k_reg;
    assign zr      = z_reg + 24'sd128;
    assign aw      = (a_reg >= 18'(lpsm_pkg::FULL_TURN)) ? a_reg - 18'(lpsm_pkg::FULL_TURN) :
                     (a_reg < 18'sd0) ? a_reg + 18'(lpsm_pkg::FULL_TURN) : a_reg;
    assign aw_r    = 18'(aw) + 18'd32;
    assign idx12   = aw_r[17:6];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpsm_pkg::ST_CLEAR:
            begin
                if (clr_reg == MA_W'(MAP_ENTRIES - 1))
                    state_next = lpsm_pkg::ST_IDLE;
            end
            lpsm_pkg::ST_IDLE:
            begin
                if (accept && s_tuser == lpsm_pkg::OP_READ)
                    state_next = lpsm_pkg::ST_MAPRD;
                else if (accept && in_frame && finish)
                    state_next = lpsm_pkg::ST_CHK;
            end
            lpsm_pkg::ST_MAPRD: state_next = lpsm_pkg::ST_FIN;
            lpsm_pkg::ST_CHK:
            begin
                if (cs_reg != cc_reg)
                    state_next = lpsm_pkg::ST_FIN;
                else
                    state_next = lpsm_pkg::ST_STEP;
            end
            lpsm_pkg::ST_STEP:
            begin
                if (lsn_reg == 8'd0)
                    state_next = lpsm_pkg::ST_FIN;
                else if (lsn_reg == 8'd1)
                    state_next = lpsm_pkg::ST_RDLO;
                else
                    state_next = lpsm_pkg::ST_DIV;
            end
            lpsm_pkg::ST_DIV:
            begin
                if (k_reg == 5'd14)
                    state_next = lpsm_pkg::ST_RDLO;
            end
            lpsm_pkg::ST_RDLO: state_next = lpsm_pkg::ST_RDHI;
            lpsm_pkg::ST_RDHI: state_next = lpsm_pkg::ST_LOAD;
            lpsm_pkg::ST_LOAD:
            begin
                if (r_word == 16'd0)
                    state_next = lpsm_pkg::ST_NEXT;
                else
                    state_next = lpsm_pkg::ST_CORD;
            end
            lpsm_pkg::ST_CORD:
            begin
                if (k_reg == 5'(lpsm_pkg::CORDIC_STEPS - 1))
                    state_next = lpsm_pkg::ST_FIX;
            end
            lpsm_pkg::ST_FIX:   state_next = lpsm_pkg::ST_WRITE;
            lpsm_pkg::ST_WRITE: state_next = lpsm_pkg::ST_NEXT;
            lpsm_pkg::ST_NEXT:
            begin
                if (samp_reg + 8'd1 == lsn_reg)
                    state_next = lpsm_pkg::ST_FIN;
                else
                    state_next = lpsm_pkg::ST_RDLO;
            end
            lpsm_pkg::ST_FIN:
            begin
                if (out_free)
                    state_next = lpsm_pkg::ST_IDLE;
            end
            default: state_next = lpsm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        prev_next     = prev_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        lsn_next      = lsn_reg;
        fsa_next      = fsa_reg;
        lsa_next      = lsa_reg;
        cc_next       = cc_reg;
        cs_next       = cs_reg;
        a0_next       = a0_reg;
        a1_next       = a1_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        acc_next      = acc_reg;
        samp_next     = samp_reg;
        ptr_next      = ptr_reg;
        lo_next       = lo_reg;
        r_next        = r_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        k_next        = k_reg;
        a_next        = a_reg;
        clr_next      = clr_reg;
        rdok_next     = rdok_reg;
        fin_stat_next = fin_stat_reg;
        fin_dist_next = fin_dist_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        dist_next     = dist_reg;
        stat_next     = stat_reg;
        fw_en         = 1'b0;
        fw_addr       = pos_reg[FA_W-1:0];
        fr_addr       = ptr_reg[FA_W-1:0];
        mw_en         = 1'b0;
        mw_addr       = clr_reg;
        mw_data       = 14'd0;
        mr_addr       = a_idx[MA_W-1:0];

        unique case (state_reg)
            lpsm_pkg::ST_CLEAR:
            begin
                mw_en    = 1'b1;
                clr_next = clr_reg + MA_W'(1);
            end
            lpsm_pkg::ST_IDLE:
            begin
                if (accept && s_tuser == lpsm_pkg::OP_READ)
                begin
                    rdok_next = 11'(a_idx) < 11'(MAP_ENTRIES);
                end
                else if (accept)
                begin
                    prev_next = rx_b;
                    if (in_frame)
                    begin
                        fw_en    = 11'(pos_reg) < 11'(MAX_FRAME_BYTES);
                        pos_next = pos_inc;
                        if (pos_reg == 10'd3) lsn_next = rx_b;
                        if (pos_reg == 10'd4) fsa_next[7:0] = rx_b;
                        if (pos_reg == 10'd5) fsa_next[15:8] = rx_b;
                        if (pos_reg == 10'd6) lsa_next[7:0] = rx_b;
                        if (pos_reg == 10'd7) lsa_next[15:8] = rx_b;
                        if (pos_reg == 10'd8) cc_next[7:0] = rx_b;
                        if (pos_reg == 10'd9) cc_next[15:8] = rx_b;
                        if (pos_reg != 10'd8 && pos_reg != 10'd9)
                        begin
                            if (pos_reg[0])
                                cs_next[15:8] = cs_reg[15:8] ^ rx_b;
                            else
                                cs_next[7:0] = cs_reg[7:0] ^ rx_b;
                        end
                        if (head_done)
                        begin
                            len_next   = len_calc;
                            phase_next = lpsm_pkg::PH_SAMP;
                        end
                        if (too_big || finish)
                        begin
                            phase_next = lpsm_pkg::PH_WAIT;
                            pos_next   = 10'd0;
                            len_next   = 10'd0;
                        end
                        if (!finish)
                        begin
                            m_tvalid_next = 1'b1;
                            dist_next     = 14'd0;
                            stat_next     = too_big ? lpsm_pkg::STAT_BIG : lpsm_pkg::STAT_NONE;
                        end
                    end
                    else
                    begin
                        if (prev_reg == lpsm_pkg::SYNC_LO && rx_b == lpsm_pkg::SYNC_HI)
                        begin
                            phase_next = lpsm_pkg::PH_HEAD;
                            pos_next   = 10'd2;
                            len_next   = 10'd0;
                            cs_next    = lpsm_pkg::SYNC_WORD;
                        end
                        m_tvalid_next = 1'b1;
                        dist_next     = 14'd0;
                        stat_next     = lpsm_pkg::STAT_NONE;
                    end
                end
            end
            lpsm_pkg::ST_MAPRD:
            begin
                fin_stat_next = lpsm_pkg::STAT_NONE;
                fin_dist_next = rdok_reg ? map_rdata_reg : 14'd0;
            end
            lpsm_pkg::ST_CHK:
            begin
                fin_dist_next = 14'd0;
                fin_stat_next = lpsm_pkg::STAT_CSUM;
                a0_next = (fsa_reg[15:1] > 15'(lpsm_pkg::FULL_TURN)) ?
                          fsa_reg[15:1] - 15'(lpsm_pkg::FULL_TURN) : fsa_reg[15:1];
                a1_next = (lsa_reg[15:1] > 15'(lpsm_pkg::FULL_TURN)) ?
                          lsa_reg[15:1] - 15'(lpsm_pkg::FULL_TURN) : lsa_reg[15:1];
            end
            lpsm_pkg::ST_STEP:
            begin
                fin_stat_next = lpsm_pkg::STAT_OK;
                dq_next       = d_adj[14:0];
                rem_next      = 8'd0;
                k_next        = 5'd0;
                step_next     = 15'd0;
                acc_next      = {1'b0, a0_reg};
                samp_next     = 8'd0;
                ptr_next      = 10'(lpsm_pkg::HEAD_BYTES);
            end
            lpsm_pkg::ST_DIV:
            begin
                rem_next = q_bit ? 8'(rem_sh - divisor) : rem_sh[7:0];
                dq_next  = {dq_reg[13:0], q_bit};
                k_next   = k_reg + 5'd1;
                if (k_reg == 5'd14)
                    step_next = {dq_reg[13:0], q_bit};
            end
            lpsm_pkg::ST_RDLO:
            begin
                fr_addr = ptr_reg[FA_W-1:0];
            end
            lpsm_pkg::ST_RDHI:
            begin
                fr_addr = FA_W'(ptr_reg + 10'd1);
                lo_next = fm_rdata_reg;
            end
            lpsm_pkg::ST_LOAD:
            begin
                r_next = r_word;
                x_next = $signed(32'(lpsm_pkg::X_GAIN * 32'(r_word)));
                y_next = $signed(lpsm_pkg::Y_BASE - 32'(lpsm_pkg::Y_GAIN * 32'(r_word)));
                z_next = 24'sd0;
                k_next = 5'd0;
            end
            lpsm_pkg::ST_CORD:
            begin
                k_next = k_reg + 5'd1;
                if (!y_reg[31])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + lpsm_pkg::atan_val(k_reg);
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - lpsm_pkg::atan_val(k_reg);
                end
            end
            lpsm_pkg::ST_FIX:
            begin
                a_next = $signed({2'b00, acc_reg}) + 18'($signed(zr[23:8]));
            end
            lpsm_pkg::ST_WRITE:
            begin
                mw_en   = 1'b1;
                mw_addr = (idx12 < 12'(MAP_ENTRIES)) ? idx12[MA_W-1:0] : MA_W'(0);
                mw_data = r_reg[15:2];
            end
            lpsm_pkg::ST_NEXT:
            begin
                samp_next = samp_reg + 8'd1;
                acc_next  = acc_reg + {1'b0, step_reg};
                ptr_next  = ptr_reg + 10'd2;
            end
            lpsm_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    dist_next     = fin_dist_reg;
                    stat_next     = fin_stat_reg;
                end
            end
            default:
            begin
                m_tvalid_next = m_tvalid_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fw_en)
            frame_mem[fw_addr] <= rx_b;
        fm_rdata_reg <= frame_mem[fr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mw_en)
            map_mem[mw_addr] <= mw_data;
        map_rdata_reg <= map_mem[mr_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lpsm_pkg::ST_CLEAR;
            phase_reg    <= lpsm_pkg::PH_WAIT;
            prev_reg     <= 8'd0;
            pos_reg      <= 10'd0;
            len_reg      <= 10'd0;
            clr_reg      <= '0;
            k_reg        <= 5'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            prev_reg     <= prev_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            clr_reg      <= clr_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lsn_reg      <= lsn_next;
        fsa_reg      <= fsa_next;
        lsa_reg      <= lsa_next;
        cc_reg       <= cc_next;
        cs_reg       <= cs_next;
        a0_reg       <= a0_next;
        a1_reg       <= a1_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        acc_reg      <= acc_next;
        samp_reg     <= samp_next;
        ptr_reg      <= ptr_next;
        lo_reg       <= lo_next;
        r_reg        <= r_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        a_reg        <= a_next;
        rdok_reg     <= rdok_next;
        fin_stat_reg <= fin_stat_next;
        fin_dist_reg <= fin_dist_next;
        dist_reg     <= dist_next;
        stat_reg     <= stat_next;
    end

endmodule

// ===== hw/rtl/lpsm_chk.sv =====
// Port checker for the lidar packet parser and scan map, with its bind.
// Depends on assert_macros.svh, lpsm_pkg and the top-level ports.
`include "assert_macros.svh"

module lpsm_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `ASSERT_HOLD(a_stat_no_dist, m_tvalid && m_tuser != lpsm_pkg::STAT_NONE, m_tdata == 16'd0)
    `ASSERT_HOLD(a_no_take_when_full, s_tready && m_tvalid, m_tready)

endmodule

bind lidar_packet_parser_scan_map_top lpsm_chk u_lpsm_chk (.*);
